// ===== rtl/core/pfn_pkg.sv =====
// Shared types and constants for the fractal gradient noise block.
// No dependencies; imported by pfn_front, pfn_back and the top level.
`default_nettype none

package pfn_pkg;

	localparam int COORD_BITS  = 12;
	localparam int FRAC_BITS   = 16;
	localparam int FREQ_BITS   = 24;
	localparam int MAX_OCTAVES = 8;
	localparam int CELL_BITS   = 8;
	localparam int OCT_BITS    = 4;
	localparam int IN_BYTES_W  = 40;
	localparam int SUM_W       = 28;

	localparam logic [FREQ_BITS-1:0] FREQ_RESET = 24'd83886;
	localparam logic [OCT_BITS-1:0]  OCT_RESET  = 4'd8;

	localparam logic CFG_BASE_FREQ = 1'b0;
	localparam logic CFG_OCTAVES   = 1'b1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef struct packed {
		logic                  render;
		logic [CELL_BITS-1:0]  table_index;
		logic [CELL_BITS-1:0]  table_value;
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
	} item_t;

	typedef struct packed {
		logic              push;
		logic [QCNT_W-1:0] count;
	} queue_status_t;

	typedef struct packed {
		logic idle;
		logic busy_render;
	} back_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/pfn_front.sv =====
// Input side: accepts transactions, classifies them and queues them.
// Depends on pfn_pkg.
`default_nettype none

module pfn_front
	import pfn_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_BYTES_W-1:0] s_axis_tdata,
	input  wire logic [0:0]            s_axis_tuser,
	output logic                       q_valid,
	output item_t                      q_item,
	input  wire logic                  q_pop,
	output queue_status_t              q_status
);

	item_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;
	item_t             in_item;

	always_comb begin
		in_item.render      = s_axis_tuser[0];
		in_item.table_index = s_axis_tdata[7:0];
		in_item.table_value = s_axis_tdata[15:8];
		in_item.pixel_x     = s_axis_tdata[27:16];
		in_item.pixel_y     = s_axis_tdata[39:28];
	end

	assign s_axis_tready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = (count_q != '0);
	assign pop           = q_pop && q_valid;
	assign q_item        = slot_q[rd_ptr_q];
	assign q_status.push  = push;
	assign q_status.count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/pfn_back.sv =====
// Execution side: permutation table, octave sequencer with one shared
// multiplier, sum mapping and output register. Depends on pfn_pkg.
`default_nettype none

module pfn_back
	import pfn_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_valid,
	input  wire item_t                q_item,
	output logic                      q_pop,
	input  wire logic [FREQ_BITS-1:0] base_freq,
	input  wire logic [OCT_BITS-1:0]  octaves,
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [7:0]                m_axis_tdata,
	output back_status_t              status
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_OCT  = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	localparam logic [3:0] K_MULX = 4'd0;
	localparam logic [3:0] K_MULY = 4'd1;
	localparam logic [3:0] K_CY   = 4'd2;
	localparam logic [3:0] K_H0   = 4'd3;
	localparam logic [3:0] K_H1   = 4'd4;
	localparam logic [3:0] K_BL   = 4'd5;
	localparam logic [3:0] K_TL   = 4'd6;
	localparam logic [3:0] K_BR   = 4'd7;
	localparam logic [3:0] K_TR   = 4'd8;
	localparam logic [3:0] K_LA   = 4'd9;
	localparam logic [3:0] K_LB   = 4'd10;
	localparam logic [3:0] K_L1   = 4'd11;
	localparam logic [3:0] K_LX   = 4'd12;
	localparam logic [3:0] K_ACC  = 4'd13;

	localparam logic [1:0] G_PP = 2'd0;
	localparam logic [1:0] G_MP = 2'd1;
	localparam logic [1:0] G_MM = 2'd2;
	localparam logic [1:0] G_PM = 2'd3;

	localparam int DW = 20;
	localparam int TW = FRAC_BITS + 1;

	function automatic logic signed [DW-1:0] grad(input logic [1:0] h,
		input logic signed [DW-1:0] dx, input logic signed [DW-1:0] dy);
		logic signed [DW-1:0] r;
		unique case (h)
			G_PP: r = dx + dy;
			G_MP: r = dy - dx;
			G_MM: r = -dx - dy;
			G_PM: r = dx - dy;
			default: r = dx - dy;
		endcase
		return r;
	endfunction

	function automatic logic signed [37:0] rnd(input logic signed [53:0] p);
		logic signed [53:0] r;
		r = (p + 54'sd32768) >>> FRAC_BITS;
		return r[37:0];
	endfunction

	function automatic logic [20:0] inner_of(input logic [TW-1:0] t2,
		input logic [FRAC_BITS-1:0] t);
		logic signed [23:0] v;
		v = 24'sd6 * $signed({7'd0, t2}) - 24'sd15 * $signed({8'd0, t})
			+ 24'sd655360;
		return v[23] ? 21'd0 : v[20:0];
	endfunction

	logic [CELL_BITS-1:0] perm_mem [256];
	logic [CELL_BITS-1:0] rd_q;
	logic [CELL_BITS-1:0] rd_addr;

	state_t                  state_q;
	logic [3:0]              step_q;
	logic [2:0]              oct_q;
	logic [OCT_BITS-1:0]     nlast_q;
	logic [COORD_BITS-1:0]   x_q, y_q;
	logic [CELL_BITS-1:0]    cx_q, cy_q, h0_q, h1_q, bl_q, tl_q, br_q;
	logic [FRAC_BITS-1:0]    fx_q, fy_q;
	logic [TW-1:0]           t2x_q, t2y_q, t3x_q, t3y_q, wx_q, wy_q;
	logic signed [DW-1:0]    dbl_q, dtl_q, dbr_q, dtr_q, l0_q, l1_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [53:0]      prod_q;
	logic signed [21:0]      mul_a;
	logic signed [31:0]      mul_b;
	logic signed [37:0]      rv;
	logic [30:0]             freq;
	logic [OCT_BITS-1:0]     n_oct;
	logic signed [DW-1:0]    fxs, fys, fxm, fym, lerp, diff;
	logic signed [SUM_W-1:0] oct_term;
	logic signed [SUM_W-1:0] biased;
	logic signed [36:0]      scaled;
	logic signed [36:0]      mapped;
	logic [7:0]              sat;
	logic                    pop;
	logic                    fin_go;

	assign pop   = (state_q == S_IDLE) && q_valid;
	assign q_pop = pop;
	assign status.idle        = (state_q == S_IDLE);
	assign status.busy_render = (state_q != S_IDLE);

	assign n_oct = (octaves > OCT_BITS'(MAX_OCTAVES)) ? OCT_BITS'(MAX_OCTAVES) : octaves;
	assign freq  = {7'd0, base_freq} << oct_q;
	assign rv    = rnd(prod_q);
	assign fxs   = $signed({4'd0, fx_q});
	assign fys   = $signed({4'd0, fy_q});
	assign fxm   = fxs - 20'sd65536;
	assign fym   = fys - 20'sd65536;
	assign lerp  = rv[DW-1:0];

	always_comb begin
		rd_addr = cx_q;
		case (step_q)
			K_CY:    rd_addr = cx_q;
			K_H0:    rd_addr = cx_q + 1'b1;
			K_H1:    rd_addr = h0_q + cy_q;
			K_BL:    rd_addr = h0_q + cy_q + 1'b1;
			K_TL:    rd_addr = h1_q + cy_q;
			K_BR:    rd_addr = h1_q + cy_q + 1'b1;
			default: rd_addr = cx_q;
		endcase
	end

	always_comb begin
		diff  = l1_q - l0_q;
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			K_MULX: begin
				mul_a = $signed({10'd0, x_q});
				mul_b = $signed({1'b0, freq});
			end
			K_MULY: begin
				mul_a = $signed({10'd0, y_q});
				mul_b = $signed({1'b0, freq});
			end
			K_CY: begin
				mul_a = $signed({6'd0, fx_q});
				mul_b = $signed({16'd0, fx_q});
			end
			K_H0: begin
				mul_a = $signed({6'd0, fy_q});
				mul_b = $signed({16'd0, fy_q});
			end
			K_H1: begin
				mul_a = $signed({5'd0, t2x_q});
				mul_b = $signed({16'd0, fx_q});
			end
			K_BL: begin
				mul_a = $signed({5'd0, t2y_q});
				mul_b = $signed({16'd0, fy_q});
			end
			K_TL: begin
				mul_a = $signed({1'b0, inner_of(t2x_q, fx_q)});
				mul_b = $signed({15'd0, t3x_q});
			end
			K_BR: begin
				mul_a = $signed({1'b0, inner_of(t2y_q, fy_q)});
				mul_b = $signed({15'd0, t3y_q});
			end
			K_LA: begin
				diff  = dtl_q - dbl_q;
				mul_a = $signed({5'd0, wy_q});
				mul_b = 32'(diff);
			end
			K_LB: begin
				diff  = dtr_q - dbr_q;
				mul_a = $signed({5'd0, wy_q});
				mul_b = 32'(diff);
			end
			K_LX: begin
				diff  = l1_q - l0_q;
				mul_a = $signed({5'd0, wx_q});
				mul_b = 32'(diff);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign oct_term = SUM_W'(l0_q + lerp) <<< (3'(MAX_OCTAVES - 1) - oct_q);

	always_comb begin
		biased = sum_q + SUM_W'(1 << (FRAC_BITS + MAX_OCTAVES - 1));
		scaled = (37'(biased) <<< 8) - 37'(biased);
		mapped = (scaled + 37'sd8388608) >>> (FRAC_BITS + MAX_OCTAVES);
		if (mapped < 0) begin
			sat = 8'd0;
		end else if (mapped > 37'sd255) begin
			sat = 8'd255;
		end else begin
			sat = mapped[7:0];
		end
	end

	assign fin_go = (state_q == S_FIN) && (!m_axis_tvalid || m_axis_tready);

	always_ff @(posedge clk) begin
		if (pop && !q_item.render) begin
			perm_mem[q_item.table_index] <= q_item.table_value;
		end
		rd_q <= perm_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (pop) begin
			x_q <= q_item.pixel_x;
			y_q <= q_item.pixel_y;
		end
		if (state_q == S_OCT) begin
			case (step_q)
				K_MULY: begin
					cx_q <= prod_q[FREQ_BITS+CELL_BITS-1:FREQ_BITS];
					fx_q <= prod_q[FREQ_BITS-1:FREQ_BITS-FRAC_BITS];
				end
				K_CY: begin
					cy_q <= prod_q[FREQ_BITS+CELL_BITS-1:FREQ_BITS];
					fy_q <= prod_q[FREQ_BITS-1:FREQ_BITS-FRAC_BITS];
				end
				K_H0: begin
					h0_q  <= rd_q;
					t2x_q <= rv[TW-1:0];
				end
				K_H1: begin
					h1_q  <= rd_q;
					t2y_q <= rv[TW-1:0];
				end
				K_BL: begin
					bl_q  <= rd_q;
					t3x_q <= rv[TW-1:0];
				end
				K_TL: begin
					tl_q  <= rd_q;
					t3y_q <= rv[TW-1:0];
				end
				K_BR: begin
					br_q <= rd_q;
					wx_q <= rv[TW-1:0];
				end
				K_TR: begin
					wy_q  <= rv[TW-1:0];
					dbl_q <= grad(bl_q[1:0], fxs, fys);
					dtl_q <= grad(tl_q[1:0], fxs, fym);
					dbr_q <= grad(br_q[1:0], fxm, fys);
					dtr_q <= grad(rd_q[1:0], fxm, fym);
				end
				K_LB: begin
					l0_q <= dbl_q + lerp;
				end
				K_L1: begin
					l1_q <= dbr_q + lerp;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			step_q        <= '0;
			oct_q         <= '0;
			nlast_q       <= '0;
			sum_q         <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready && !fin_go) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop && q_item.render) begin
						sum_q   <= '0;
						oct_q   <= '0;
						step_q  <= K_MULX;
						nlast_q <= n_oct - 1'b1;
						state_q <= (n_oct == '0) ? S_FIN : S_OCT;
					end
				end
				S_OCT: begin
					if (step_q == K_ACC) begin
						sum_q  <= sum_q + oct_term;
						step_q <= K_MULX;
						if ({1'b0, oct_q} == nlast_q) begin
							state_q <= S_FIN;
						end else begin
							oct_q <= oct_q + 1'b1;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= sat;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/perlin_fractal_noise_2d.sv =====
// Top level of the 2-D fractal gradient noise generator.
// Depends on pfn_pkg, pfn_front and pfn_back.
`default_nettype none

// Load transactions (tuser = 0) write one byte of the 256-entry permutation
// table in the execution unit; every table entry must be loaded before the
// first render. Render transactions (tuser = 1) return one noise byte and run
// N = min(octave_count, 8) octaves, every step of an octave sharing the single
// multiplier and the single-port table read. A four-entry queue decouples
// input acceptance from execution, and the result register lets the next
// transaction start while a result waits.
// Write configuration only while the block is idle.
module perlin_fractal_noise_2d
	import pfn_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// [7:0] table_index, [15:8] table_value, [27:16] pixel_x, [39:28] pixel_y
	input  wire logic [IN_BYTES_W-1:0] s_axis_tdata,
	// [0] mode
	input  wire logic [0:0]            s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// [7:0] noise_value
	output logic [7:0]                 m_axis_tdata,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [FREQ_BITS-1:0]  cfg_data
);

	logic [FREQ_BITS-1:0] base_freq_q;
	logic [OCT_BITS-1:0]  octaves_q;
	logic                 q_valid;
	item_t                q_item;
	logic                 q_pop;
	queue_status_t        q_status;
	back_status_t         b_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_freq_q <= FREQ_RESET;
			octaves_q   <= OCT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BASE_FREQ: base_freq_q <= cfg_data;
				CFG_OCTAVES:   octaves_q   <= cfg_data[OCT_BITS-1:0];
				default:       base_freq_q <= base_freq_q;
			endcase
		end
	end

	pfn_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.q_status      (q_status)
	);

	pfn_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.base_freq     (base_freq_q),
		.octaves       (octaves_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.status        (b_status)
	);

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.count <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_queue_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(q_status.push && !q_pop) |=> (q_status.count == $past(q_status.count) + 1'b1))
		else $error("queue count did not advance on push");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (b_status.idle && q_valid))
		else $error("queue popped while execution busy");
`endif

endmodule

`default_nettype wire

// ===== tb/perlin_fractal_noise_2d_tb.sv =====
// Self-checking testbench for perlin_fractal_noise_2d: loads the permutation table,
// renders pixels under several configurations and checks each noise byte.
// Depends on pfn_pkg and the perlin_fractal_noise_2d RTL.
`default_nettype none

class noise_scoreboard;
	bit [7:0]  perm [256];
	bit [23:0] freq;
	bit [3:0]  octaves;
	bit [7:0]  noise_q [$];
	int        errors;

	function new();
		freq    = pfn_pkg::FREQ_RESET;
		octaves = pfn_pkg::OCT_RESET;
		errors  = 0;
	endfunction

	function longint rnd_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function longint fade(longint t);
		longint t2, t3, inner;
		t2 = rnd_shift(t * t, 16);
		t3 = rnd_shift(t2 * t, 16);
		inner = 6 * t2 - 15 * t + 10 * 65536;
		if (inner < 0)
			inner = 0;
		return rnd_shift(t3 * inner, 16);
	endfunction

	function longint mix(longint w, longint a, longint b);
		return a + rnd_shift(w * (b - a), 16);
	endfunction

	function longint gdot(bit [7:0] h, longint dx, longint dy);
		case (h[1:0])
			2'd0: return dx + dy;
			2'd1: return -dx + dy;
			2'd2: return -dx - dy;
			default: return dx - dy;
		endcase
	endfunction

	function longint octave_value(longint px, longint py);
		bit [7:0] cx, cy, h0, h1, bl, tl, br, tr;
		longint fx, fy, wx, wy;
		cx = px[31:24];
		cy = py[31:24];
		fx = longint'(px[23:8]);
		fy = longint'(py[23:8]);
		h0 = perm[cx];
		h1 = perm[8'(cx + 1)];
		bl = perm[8'(h0 + cy)];
		tl = perm[8'(h0 + cy + 1)];
		br = perm[8'(h1 + cy)];
		tr = perm[8'(h1 + cy + 1)];
		wx = fade(fx);
		wy = fade(fy);
		return mix(wx, mix(wy, gdot(bl, fx, fy), gdot(tl, fx, fy - 65536)),
			mix(wy, gdot(br, fx - 65536, fy), gdot(tr, fx - 65536, fy - 65536)));
	endfunction

	function void note_input(bit mode, bit [7:0] idx, bit [7:0] val,
			bit [11:0] x, bit [11:0] y);
		longint sum, f, v;
		int n;
		if (!mode) begin
			perm[idx] = val;
			return;
		end
		sum = 0;
		n = (octaves > 8) ? 8 : octaves;
		for (int o = 0; o < n; o++) begin
			f = longint'(freq) << o;
			sum += octave_value(longint'(x) * f, longint'(y) * f) * (longint'(1) << (7 - o));
		end
		v = rnd_shift(255 * (sum + (longint'(1) << 23)), 24);
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		noise_q.push_back(8'(v));
	endfunction

	function void check(bit [7:0] got);
		bit [7:0] want;
		if (noise_q.size() == 0) begin
			$display("%0t: unexpected noise_value, expected none, actual %0d", $time, got);
			errors++;
			return;
		end
		want = noise_q.pop_front();
		if (want !== got) begin
			$display("%0t: noise_value mismatch, expected %0d, actual %0d", $time, want, got);
			errors++;
		end
	endfunction
endclass

module perlin_fractal_noise_2d_tb;
	import pfn_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_BYTES_W-1:0] s_axis_tdata;
	logic [0:0]            s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [7:0]            m_axis_tdata;
	logic                  cfg_we;
	logic                  cfg_index;
	logic [FREQ_BITS-1:0]  cfg_data;

	noise_scoreboard sb;
	bit no_gaps;
	bit [7:0] shuffle [256];

	perlin_fractal_noise_2d dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 3000000);
		$display("Verification failed");
		$finish;
	end

	function automatic int draw_gap();
		return no_gaps ? 0 : $urandom_range(0, 17);
	endfunction

	task automatic send(bit mode, bit [7:0] idx, bit [7:0] val, bit [11:0] x, bit [11:0] y);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {y, x, val, idx};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_input(mode, idx, val, x, y);
	endtask

	task automatic render(bit [11:0] x, bit [11:0] y);
		send(1'b1, 8'd0, 8'd0, x, y);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.noise_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic configure(bit [23:0] f, bit [3:0] n);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_BASE_FREQ;
		cfg_data  <= f;
		@(posedge clk);
		cfg_index <= CFG_OCTAVES;
		cfg_data  <= {20'd0, n};
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.freq    = f;
		sb.octaves = n;
	endtask

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 4) == 0)
				send(1'b0, 8'($urandom), 8'($urandom), 12'($urandom), 12'($urandom));
			else
				render(12'($urandom), 12'($urandom));
		end
	endtask

	always begin
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			m_axis_tready <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		m_axis_tready <= 1'b1;
		@(posedge clk);
		while (!m_axis_tvalid)
			@(posedge clk);
		sb.check(m_axis_tdata);
	end

	initial begin
		int j;
		bit [7:0] tmp;
		sb = new();
		no_gaps = 1'b0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_BASE_FREQ;
		cfg_data      <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 256; i++)
			shuffle[i] = 8'(i);
		for (int i = 255; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = shuffle[i];
			shuffle[i] = shuffle[j];
			shuffle[j] = tmp;
		end
		for (int i = 0; i < 256; i++)
			send(1'b0, 8'(i), shuffle[i], 12'd0, 12'd0);

		// corners of the coordinate range and one interior pixel at reset settings
		render(12'd0, 12'd0);
		render(12'hFFF, 12'hFFF);
		render(12'hFFF, 12'd0);
		render(12'd0, 12'hFFF);
		render(12'hAAA, 12'h555);
		configure(24'hFFFFFF, 4'd8);
		render(12'd1, 12'd1);
		render(12'hFFF, 12'h800);
		render(12'h123, 12'hEDC);
		configure(24'd0, 4'd8);
		render(12'h7FF, 12'h3A5);
		configure(24'd1, 4'd1);
		render(12'hFFF, 12'hFFF);
		configure(24'h100000, 4'd0);
		render(12'h456, 12'h789);
		configure(24'h0A0000, 4'd15);
		render(12'h321, 12'hCBA);
		render(12'hFFF, 12'd7);

		configure(FREQ_RESET, OCT_RESET);
		random_phase(110);
		configure(24'($urandom_range(1, 24'hFFFFFF)), 4'($urandom_range(1, 8)));
		no_gaps = 1'b1;
		random_phase(90);
		no_gaps = 1'b0;
		configure(24'hFFFFFF, 4'd1);
		random_phase(90);
		configure(24'd1, 4'd8);
		random_phase(70);
		configure(24'($urandom_range(1, 24'h40000)), 4'($urandom_range(9, 15)));
		random_phase(90);
		configure(24'($urandom), 4'($urandom_range(0, 15)));
		random_phase(80);
		configure(24'($urandom_range(1, 24'h200000)), 4'($urandom_range(2, 6)));
		random_phase(50);

		drain();
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

`default_nettype wire
